/* hw/rtl/kci_pkg.sv */
package kci_pkg;

   localparam int MAX_KEYS = 64;
   localparam int ADDR_W = $clog2(MAX_KEYS);
   localparam int CNT_W = $clog2(MAX_KEYS + 1);
   localparam int ACC_W = 40;
   localparam int DIV_N_W = 48;
   localparam int DIV_D_W = 33;
   localparam int DIV_CNT_W = $clog2(DIV_N_W);
   localparam int U_W = 16;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_EVAL   = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      TAN_CONST   = 2'd0,
      TAN_LINEAR  = 2'd1,
      TAN_HERMITE = 2'd2,
      TAN_CATMULL = 2'd3
   } tangent_type;

   typedef enum logic [1:0] {
      WRAP_ONCE = 2'd0,
      WRAP_LOOP = 2'd1,
      WRAP_TRIP = 2'd2
   } wrap_type;

   typedef enum logic {
      CSR_WRAP_MODE     = 1'b0,
      CSR_DEFAULT_VALUE = 1'b1
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_INS_PUT,
      ST_EV_LRD,
      ST_EV_L,
      ST_EV_WDIV,
      ST_EV_0RD,
      ST_EV_0,
      ST_EV_SRD,
      ST_EV_S,
      ST_EV_K1RD,
      ST_EV_K1,
      ST_EV_PRD,
      ST_EV_P,
      ST_EV_NRD,
      ST_EV_N,
      ST_EV_UDIV,
      ST_EV_SETUP,
      ST_EV_MUL,
      ST_EV_ADD,
      ST_EV_WRES,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic               command;
      logic signed [31:0] key_time;
      logic signed [31:0] key_value;
      logic [1:0]         tangent_mode;
      logic signed [31:0] tangent_slope;
   } req_type;

   typedef struct packed {
      logic signed [31:0] curve_value;
      logic               status;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] ktime;
      logic signed [31:0] kvalue;
      tangent_type        rmode;
      logic signed [31:0] rslope;
      tangent_type        lmode;
      logic signed [31:0] lslope;
   } entry_type;

   typedef struct packed {
      logic               start;
      logic [DIV_N_W-1:0] dividend;
      logic [DIV_D_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic [DIV_N_W-1:0] quot;
      logic [DIV_D_W-1:0] rem;
   } div_rsp_type;

   function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = ACC_W'(32'sh7fffffff);
      lo = ACC_W'(-32'sh7fffffff - 32'sd1);
      if (v > hi) begin
         return 32'sh7fffffff;
      end else if (v < lo) begin
         return -32'sh7fffffff - 32'sd1;
      end
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
      if (v == (-32'sh7fffffff - 32'sd1)) begin
         return 32'sh7fffffff;
      end
      return -v;
   endfunction

   function automatic logic signed [ACC_W-1:0] sxa(input logic signed [31:0] v);
      return {{(ACC_W-32){v[31]}}, v};
   endfunction

   function automatic logic signed [33:0] sx34(input logic signed [31:0] v);
      return {{2{v[31]}}, v};
   endfunction

   function automatic logic signed [32:0] sx33(input logic signed [31:0] v);
      return {v[31], v};
   endfunction

endpackage

/* hw/rtl/kci_div.sv */
module kci_div (
   input  logic                 clock,
   input  logic                 reset,
   input  kci_pkg::div_req_type div_req,
   output kci_pkg::div_rsp_type div_rsp
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [kci_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [kci_pkg::DIV_D_W-1:0]   rem_ff, rem_in;
   logic [kci_pkg::DIV_N_W-1:0]   quot_ff, quot_in;
   logic [kci_pkg::DIV_D_W-1:0]   d_ff, d_in;
   logic [kci_pkg::DIV_D_W:0]     shifted;
   logic                          ge;

   assign shifted = {rem_ff, quot_ff[kci_pkg::DIV_N_W-1]};
   assign ge = shifted >= {1'b0, d_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quot_in = quot_ff;
      d_in = d_ff;
      if (div_req.start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in = kci_pkg::DIV_CNT_W'(kci_pkg::DIV_N_W - 1);
         rem_in = '0;
         quot_in = div_req.dividend;
         d_in = div_req.divisor;
      end else if (busy_ff) begin
         // one quotient bit per cycle
         if (ge) begin
            rem_in = kci_pkg::DIV_D_W'(shifted - {1'b0, d_ff});
         end else begin
            rem_in = shifted[kci_pkg::DIV_D_W-1:0];
         end
         quot_in = {quot_ff[kci_pkg::DIV_N_W-2:0], ge};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quot_ff <= quot_in;
      d_ff <= d_in;
   end

   assign div_rsp.busy = busy_ff;
   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;
   assign div_rsp.rem = rem_ff;

endmodule

/* hw/rtl/keyframe_curve_interpolator.sv */
// Insert: if full, straight to the result; if empty, a direct write; else keys are read from
// the top and each later key moved up one slot, then the write and the result register.
// Evaluate: the default if empty; else a key scan, up to two divider runs (time wrap and
// fraction) and up to 7 multiply-add steps. The bit-serial divider and the single table
// read port set the run time. One item at a time; the next item is taken while a result waits.
// Reset clears the key count, CSR registers and control; table contents stay undefined.
module keyframe_curve_interpolator (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  kci_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output kci_pkg::rsp_type rsp_data,
   input  logic             csr_write,
   input  logic             csr_index,
   input  logic [31:0]      csr_wdata
);

   localparam int PROD_W = kci_pkg::ACC_W + kci_pkg::U_W + 1;

   kci_pkg::entry_type mem [kci_pkg::MAX_KEYS];
   kci_pkg::entry_type rd_q_ff;
   logic [kci_pkg::ADDR_W-1:0] rd_addr;
   logic                       mem_we;
   logic [kci_pkg::ADDR_W-1:0] mem_waddr;
   kci_pkg::entry_type         mem_wdata;

   kci_pkg::state_type state_ff, state_in;
   logic [kci_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [kci_pkg::ADDR_W-1:0] idx_ff, idx_in;
   logic [kci_pkg::ADDR_W-1:0] pos_ff, pos_in;
   logic [1:0]                 wrap_mode_ff, wrap_mode_in;
   logic signed [31:0]         default_ff, default_in;
   kci_pkg::req_type           req_ff, req_in;
   logic signed [33:0]         x_ff, x_in;
   logic signed [31:0]         tl_ff, tl_in, vl_ff, vl_in, t0_ff, t0_in, v0_ff, v0_in;
   logic signed [31:0]         tk0_ff, tk0_in, vk0_ff, vk0_in, rs_ff, rs_in;
   logic signed [31:0]         tk1_ff, tk1_in, vk1_ff, vk1_in, ls_ff, ls_in;
   kci_pkg::tangent_type       rm_ff, rm_in, lm_ff, lm_in;
   logic signed [31:0]         vprev_ff, vprev_in, vnext_ff, vnext_in;
   kci_pkg::tangent_type       lmode_new_ff, lmode_new_in;
   logic signed [31:0]         lslope_new_ff, lslope_new_in;
   logic [kci_pkg::U_W-1:0]    u_ff, u_in;
   logic signed [kci_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic signed [kci_pkg::ACC_W-1:0] add_ff [3];
   logic signed [kci_pkg::ACC_W-1:0] add_in [3];
   logic [1:0]                 step_ff, step_in, last_ff, last_in, phase_ff, phase_in;
   logic                       halve_ff, halve_in;
   logic signed [31:0]         w0_ff, w0_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   kci_pkg::rsp_type           res_ff, res_in;
   kci_pkg::rsp_type           rsp_ff, rsp_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   kci_pkg::div_req_type div_req;
   kci_pkg::div_rsp_type div_rsp;

   // datapath terms
   logic signed [33:0] x_abs;
   logic signed [32:0] tl33, tl_abs, fr33, fr_abs;
   logic signed [33:0] rem_s;
   logic signed [35:0] fr36, r36;
   logic               trip_low;
   logic signed [33:0] trip_x;
   logic signed [33:0] diff34;
   logic signed [32:0] den33;
   logic signed [kci_pkg::ACC_W-1:0] p0a, p1a, s1a, s2a, v1a, v4a;
   logic signed [kci_pkg::ACC_W-1:0] prod_sh, wres_r;
   logic signed [PROD_W-1:0] prod_full;
   kci_pkg::tangent_type     cur_mode;
   logic signed [31:0]       wres_w;

   assign x_abs = x_ff[33] ? -x_ff : x_ff;
   assign tl33 = kci_pkg::sx33(rd_q_ff.ktime);
   assign tl_abs = tl33[32] ? -tl33 : tl33;
   assign fr33 = {rd_q_ff.ktime, 1'b0};
   assign fr_abs = fr33[32] ? -fr33 : fr33;
   assign rem_s = x_ff[33] ? -$signed({1'b0, div_rsp.rem}) : $signed({1'b0, div_rsp.rem});
   assign fr36 = {{3{tl_ff[31]}}, tl_ff, 1'b0};
   assign r36 = {{2{rem_s[33]}}, rem_s};
   assign trip_low = (fr36 > 36'sd0) ? ((r36 <<< 1) <= fr36) : ((r36 <<< 1) >= fr36);
   assign trip_x = trip_low ? rem_s : 34'(fr36 - r36);
   assign diff34 = x_ff - kci_pkg::sx34(tk0_ff);
   assign den33 = kci_pkg::sx33(tk1_ff) - kci_pkg::sx33(tk0_ff);
   assign p0a = kci_pkg::sxa(vk0_ff);
   assign p1a = kci_pkg::sxa(vk1_ff);
   assign s1a = kci_pkg::sxa(rs_ff);
   assign s2a = kci_pkg::sxa(ls_ff);
   assign v1a = kci_pkg::sxa(vprev_ff);
   assign v4a = kci_pkg::sxa(vnext_ff);
   assign prod_full = acc_ff * $signed({1'b0, u_ff});
   assign prod_sh = kci_pkg::ACC_W'(prod_ff >>> 16);
   assign wres_r = halve_ff ? (acc_ff >>> 1) : acc_ff;
   assign wres_w = kci_pkg::sat32(wres_r);
   assign cur_mode = (phase_ff == 2'd0) ? rm_ff : lm_ff;

   kci_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      pos_in = pos_ff;
      wrap_mode_in = wrap_mode_ff;
      default_in = default_ff;
      req_in = req_ff;
      x_in = x_ff;
      tl_in = tl_ff;
      vl_in = vl_ff;
      t0_in = t0_ff;
      v0_in = v0_ff;
      tk0_in = tk0_ff;
      vk0_in = vk0_ff;
      rm_in = rm_ff;
      rs_in = rs_ff;
      tk1_in = tk1_ff;
      vk1_in = vk1_ff;
      lm_in = lm_ff;
      ls_in = ls_ff;
      vprev_in = vprev_ff;
      vnext_in = vnext_ff;
      lmode_new_in = lmode_new_ff;
      lslope_new_in = lslope_new_ff;
      u_in = u_ff;
      acc_in = acc_ff;
      add_in = add_ff;
      step_in = step_ff;
      last_in = last_ff;
      phase_in = phase_ff;
      halve_in = halve_ff;
      w0_in = w0_ff;
      prod_in = prod_ff;
      res_in = res_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      rd_addr = idx_ff;
      mem_we = 1'b0;
      mem_waddr = pos_ff;
      mem_wdata = rd_q_ff;
      div_req.start = 1'b0;
      div_req.dividend = {{(kci_pkg::DIV_N_W-34){1'b0}}, x_abs};
      div_req.divisor = tl_abs;

      if (csr_write) begin
         case (csr_index)
            kci_pkg::CSR_WRAP_MODE: wrap_mode_in = csr_wdata[1:0];
            kci_pkg::CSR_DEFAULT_VALUE: default_in = csr_wdata;
            default: wrap_mode_in = wrap_mode_ff;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         kci_pkg::ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               res_in.curve_value = '0;
               res_in.status = 1'b0;
               if (req_data.command == kci_pkg::CMD_EVAL) begin
                  x_in = kci_pkg::sx34(req_data.key_time);
                  if (cnt_ff == '0) begin
                     res_in.curve_value = default_ff;
                     state_in = kci_pkg::ST_RESP;
                  end else begin
                     state_in = kci_pkg::ST_EV_LRD;
                  end
               end else if (cnt_ff >= kci_pkg::CNT_W'(kci_pkg::MAX_KEYS)) begin
                  res_in.status = 1'b1;
                  state_in = kci_pkg::ST_RESP;
               end else if (cnt_ff == '0) begin
                  pos_in = '0;
                  lmode_new_in = kci_pkg::TAN_CONST;
                  lslope_new_in = '0;
                  state_in = kci_pkg::ST_INS_PUT;
               end else begin
                  idx_in = kci_pkg::ADDR_W'(cnt_ff - 1'b1);
                  state_in = kci_pkg::ST_INS_RD;
               end
            end
         end
         kci_pkg::ST_INS_RD: begin
            rd_addr = idx_ff;
            state_in = kci_pkg::ST_INS_CMP;
         end
         kci_pkg::ST_INS_CMP: begin
            if (rd_q_ff.ktime <= req_ff.key_time) begin
               pos_in = kci_pkg::ADDR_W'(idx_ff + 1'b1);
               lmode_new_in = rd_q_ff.rmode;
               lslope_new_in = kci_pkg::neg_sat(rd_q_ff.rslope);
               state_in = kci_pkg::ST_INS_PUT;
            end else begin
               // move the key up one slot
               mem_we = 1'b1;
               mem_waddr = kci_pkg::ADDR_W'(idx_ff + 1'b1);
               mem_wdata = rd_q_ff;
               if (idx_ff == '0) begin
                  pos_in = '0;
                  lmode_new_in = kci_pkg::TAN_CONST;
                  lslope_new_in = '0;
                  state_in = kci_pkg::ST_INS_PUT;
               end else begin
                  idx_in = idx_ff - 1'b1;
                  state_in = kci_pkg::ST_INS_RD;
               end
            end
         end
         kci_pkg::ST_INS_PUT: begin
            mem_we = 1'b1;
            mem_waddr = pos_ff;
            mem_wdata.ktime = req_ff.key_time;
            mem_wdata.kvalue = req_ff.key_value;
            mem_wdata.rmode = kci_pkg::tangent_type'(req_ff.tangent_mode);
            mem_wdata.rslope = req_ff.tangent_slope;
            mem_wdata.lmode = lmode_new_ff;
            mem_wdata.lslope = lslope_new_ff;
            cnt_in = cnt_ff + 1'b1;
            state_in = kci_pkg::ST_RESP;
         end
         kci_pkg::ST_EV_LRD: begin
            rd_addr = kci_pkg::ADDR_W'(cnt_ff - 1'b1);
            state_in = kci_pkg::ST_EV_L;
         end
         kci_pkg::ST_EV_L: begin
            tl_in = rd_q_ff.ktime;
            vl_in = rd_q_ff.kvalue;
            state_in = kci_pkg::ST_EV_0RD;
            case (wrap_mode_ff)
               kci_pkg::WRAP_LOOP: begin
                  if (rd_q_ff.ktime == '0) begin
                     x_in = '0;
                  end else begin
                     div_req.start = 1'b1;
                     div_req.divisor = tl_abs;
                     state_in = kci_pkg::ST_EV_WDIV;
                  end
               end
               kci_pkg::WRAP_TRIP: begin
                  if (rd_q_ff.ktime == '0) begin
                     x_in = '0;
                  end else begin
                     div_req.start = 1'b1;
                     div_req.divisor = fr_abs;
                     state_in = kci_pkg::ST_EV_WDIV;
                  end
               end
               default: x_in = x_ff;
            endcase
         end
         kci_pkg::ST_EV_WDIV: begin
            if (div_rsp.done) begin
               x_in = (wrap_mode_ff == kci_pkg::WRAP_LOOP) ? rem_s : trip_x;
               state_in = kci_pkg::ST_EV_0RD;
            end
         end
         kci_pkg::ST_EV_0RD: begin
            rd_addr = '0;
            state_in = kci_pkg::ST_EV_0;
         end
         kci_pkg::ST_EV_0: begin
            t0_in = rd_q_ff.ktime;
            v0_in = rd_q_ff.kvalue;
            if (x_ff < kci_pkg::sx34(rd_q_ff.ktime)) begin
               res_in.curve_value = default_ff;
               state_in = kci_pkg::ST_RESP;
            end else if (cnt_ff == kci_pkg::CNT_W'(1)) begin
               res_in.curve_value = rd_q_ff.kvalue;
               state_in = kci_pkg::ST_RESP;
            end else if (x_ff >= kci_pkg::sx34(tl_ff)) begin
               res_in.curve_value = vl_ff;
               state_in = kci_pkg::ST_RESP;
            end else begin
               idx_in = kci_pkg::ADDR_W'(cnt_ff - 2'd2);
               state_in = kci_pkg::ST_EV_SRD;
            end
         end
         kci_pkg::ST_EV_SRD: begin
            rd_addr = idx_ff;
            state_in = kci_pkg::ST_EV_S;
         end
         kci_pkg::ST_EV_S: begin
            if (kci_pkg::sx34(rd_q_ff.ktime) <= x_ff) begin
               tk0_in = rd_q_ff.ktime;
               vk0_in = rd_q_ff.kvalue;
               rm_in = rd_q_ff.rmode;
               rs_in = rd_q_ff.rslope;
               state_in = kci_pkg::ST_EV_K1RD;
            end else begin
               idx_in = idx_ff - 1'b1;
               state_in = kci_pkg::ST_EV_SRD;
            end
         end
         kci_pkg::ST_EV_K1RD: begin
            rd_addr = kci_pkg::ADDR_W'(idx_ff + 1'b1);
            state_in = kci_pkg::ST_EV_K1;
         end
         kci_pkg::ST_EV_K1: begin
            tk1_in = rd_q_ff.ktime;
            vk1_in = rd_q_ff.kvalue;
            lm_in = rd_q_ff.lmode;
            ls_in = rd_q_ff.lslope;
            state_in = kci_pkg::ST_EV_PRD;
         end
         kci_pkg::ST_EV_PRD: begin
            rd_addr = (idx_ff == '0) ? '0 : idx_ff - 1'b1;
            state_in = kci_pkg::ST_EV_P;
         end
         kci_pkg::ST_EV_P: begin
            vprev_in = (tk0_ff == t0_ff) ? vl_ff : rd_q_ff.kvalue;
            state_in = kci_pkg::ST_EV_NRD;
         end
         kci_pkg::ST_EV_NRD: begin
            if ((kci_pkg::CNT_W'(idx_ff) + 2'd2) < cnt_ff) begin
               rd_addr = kci_pkg::ADDR_W'(idx_ff + 2'd2);
            end else begin
               rd_addr = kci_pkg::ADDR_W'(cnt_ff - 1'b1);
            end
            state_in = kci_pkg::ST_EV_N;
         end
         kci_pkg::ST_EV_N: begin
            vnext_in = (tk1_ff == tl_ff) ? v0_ff : rd_q_ff.kvalue;
            div_req.start = 1'b1;
            div_req.dividend = {diff34[31:0], 16'h0000};
            div_req.divisor = den33;
            state_in = kci_pkg::ST_EV_UDIV;
         end
         kci_pkg::ST_EV_UDIV: begin
            if (div_rsp.done) begin
               u_in = div_rsp.quot[kci_pkg::U_W-1:0];
               phase_in = 2'd0;
               state_in = kci_pkg::ST_EV_SETUP;
            end
         end
         kci_pkg::ST_EV_SETUP: begin
            step_in = 2'd0;
            halve_in = 1'b0;
            state_in = kci_pkg::ST_EV_MUL;
            case (cur_mode)
               kci_pkg::TAN_CONST: begin
                  acc_in = p0a;
                  state_in = kci_pkg::ST_EV_WRES;
               end
               kci_pkg::TAN_LINEAR: begin
                  acc_in = p1a - p0a;
                  add_in[0] = p0a;
                  last_in = 2'd0;
               end
               kci_pkg::TAN_HERMITE: begin
                  acc_in = 2 * (p0a - p1a) + (s1a + s2a);
                  add_in[0] = 3 * (p1a - p0a) - 2 * s1a - s2a;
                  add_in[1] = s1a;
                  add_in[2] = p0a;
                  last_in = 2'd2;
               end
               default: begin
                  acc_in = -v1a + 3 * p0a - 3 * p1a + v4a;
                  add_in[0] = 2 * v1a - 5 * p0a + 4 * p1a - v4a;
                  add_in[1] = p1a - v1a;
                  add_in[2] = 2 * p0a;
                  last_in = 2'd2;
                  halve_in = 1'b1;
               end
            endcase
         end
         kci_pkg::ST_EV_MUL: begin
            prod_in = prod_full;
            state_in = kci_pkg::ST_EV_ADD;
         end
         kci_pkg::ST_EV_ADD: begin
            acc_in = prod_sh + add_ff[step_ff];
            if (step_ff == last_ff) begin
               state_in = kci_pkg::ST_EV_WRES;
            end else begin
               step_in = step_ff + 1'b1;
               state_in = kci_pkg::ST_EV_MUL;
            end
         end
         kci_pkg::ST_EV_WRES: begin
            case (phase_ff)
               2'd0: begin
                  w0_in = wres_w;
                  phase_in = 2'd1;
                  state_in = kci_pkg::ST_EV_SETUP;
               end
               2'd1: begin
                  // blend the two interpolations
                  acc_in = kci_pkg::sxa(wres_w) - kci_pkg::sxa(w0_ff);
                  add_in[0] = kci_pkg::sxa(w0_ff);
                  step_in = 2'd0;
                  last_in = 2'd0;
                  halve_in = 1'b0;
                  phase_in = 2'd2;
                  state_in = kci_pkg::ST_EV_MUL;
               end
               default: begin
                  res_in.curve_value = wres_w;
                  state_in = kci_pkg::ST_RESP;
               end
            endcase
         end
         kci_pkg::ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in = res_ff;
               rsp_valid_in = 1'b1;
               state_in = kci_pkg::ST_IDLE;
            end
         end
         default: state_in = kci_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_q_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kci_pkg::ST_IDLE;
         cnt_ff <= '0;
         wrap_mode_ff <= kci_pkg::WRAP_ONCE;
         default_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         wrap_mode_ff <= wrap_mode_in;
         default_ff <= default_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff <= idx_in;
      pos_ff <= pos_in;
      req_ff <= req_in;
      x_ff <= x_in;
      tl_ff <= tl_in;
      vl_ff <= vl_in;
      t0_ff <= t0_in;
      v0_ff <= v0_in;
      tk0_ff <= tk0_in;
      vk0_ff <= vk0_in;
      rm_ff <= rm_in;
      rs_ff <= rs_in;
      tk1_ff <= tk1_in;
      vk1_ff <= vk1_in;
      lm_ff <= lm_in;
      ls_ff <= ls_in;
      vprev_ff <= vprev_in;
      vnext_ff <= vnext_in;
      lmode_new_ff <= lmode_new_in;
      lslope_new_ff <= lslope_new_in;
      u_ff <= u_in;
      acc_ff <= acc_in;
      add_ff <= add_in;
      step_ff <= step_in;
      last_ff <= last_in;
      phase_ff <= phase_in;
      halve_ff <= halve_in;
      w0_ff <= w0_in;
      prod_ff <= prod_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   assign req_stall = (state_ff != kci_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= kci_pkg::CNT_W'(kci_pkg::MAX_KEYS))
      else $error("key count beyond table depth");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == kci_pkg::ST_RESP))
      else $error("result raised outside response state");

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");
`endif

endmodule
